// ===== hw/rtl/obbsat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obbsat_pkg
// Shared types, pipeline depths and helpers for the rectangle pair
// collision pipeline.
// ----------------------------------------------------------------------------
package obbsat_pkg;

    localparam int AXIS_BITS  = 30;
    localparam int MULT_BITS  = 16;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = AXIS_BITS + 1;
    // edge, square, sum, root bits, quotient bits, output
    localparam int AXIS_LAT   = 3 + SQRT_STEPS + DIV_STEPS + 1;
    localparam int POST_LAT   = 9;
    localparam int TOTAL_LAT  = AXIS_LAT + POST_LAT;

    localparam logic [16:0] MULT_RESET = 17'd32768;

    typedef struct packed {
        logic [7:0][63:0] corner;
        logic [63:0]      ctr_a;
        logic [63:0]      ctr_b;
        logic [31:0]      spd_a;
        logic [31:0]      spd_b;
    } pass_t;

    typedef struct packed {
        logic [63:0] ctr_a;
        logic [63:0] ctr_b;
        logic [31:0] spd_a;
        logic [31:0] spd_b;
    } side_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -36'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/obbsat_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obbsat_axis
// Unit edge axis of one rectangle in Q2.30: saturated edge, squared length,
// pipelined integer square root, pipelined restoring division.
// ----------------------------------------------------------------------------
module obbsat_axis
    import obbsat_pkg::*;
(
    input  logic               clk,
    input  logic [63:0]        p0,
    input  logic [63:0]        p1,
    output logic signed [31:0] axis_x,
    output logic signed [31:0] axis_y
);

    typedef struct packed {
        logic        zero;
        logic        nx;
        logic        ny;
        logic [30:0] mx;
        logic [30:0] my;
        logic [63:0] n;
        logic [33:0] rem;
        logic [31:0] root;
    } sq_t;

    typedef struct packed {
        logic        zero;
        logic        nx;
        logic        ny;
        logic        bx;
        logic        by;
        logic [31:0] len;
        logic [31:0] remx;
        logic [31:0] remy;
        logic [30:0] qx;
        logic [30:0] qy;
    } dv_t;

    logic signed [32:0] ex;
    logic signed [32:0] ey;
    logic [32:0]        ex_abs;
    logic [32:0]        ey_abs;

    logic [30:0] e_mx_reg;
    logic [30:0] e_my_reg;
    logic        e_nx_reg;
    logic        e_ny_reg;
    logic [61:0] q_sx_reg;
    logic [61:0] q_sy_reg;
    logic [30:0] q_mx_reg;
    logic [30:0] q_my_reg;
    logic        q_nx_reg;
    logic        q_ny_reg;

    sq_t sq_reg [SQRT_STEPS+1];
    dv_t dv_in;
    dv_t dv_reg [1:DIV_STEPS];

    logic signed [31:0] axis_x_reg;
    logic signed [31:0] axis_y_reg;

    // edge, saturated symmetric to +/-(2^31-1)
    always_comb
    begin
        ex     = $signed({p1[63], p1[63:32]}) - $signed({p0[63], p0[63:32]});
        ey     = $signed({p1[31], p1[31:0]}) - $signed({p0[31], p0[31:0]});
        ex_abs = ex[32] ? 33'(-ex) : 33'(ex);
        ey_abs = ey[32] ? 33'(-ey) : 33'(ey);
    end

    always_ff @(posedge clk)
    begin
        e_mx_reg <= (ex_abs > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : ex_abs[30:0];
        e_my_reg <= (ey_abs > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : ey_abs[30:0];
        e_nx_reg <= ex[32];
        e_ny_reg <= ey[32];

        q_sx_reg <= {31'b0, e_mx_reg} * {31'b0, e_mx_reg};
        q_sy_reg <= {31'b0, e_my_reg} * {31'b0, e_my_reg};
        q_mx_reg <= e_mx_reg;
        q_my_reg <= e_my_reg;
        q_nx_reg <= e_nx_reg;
        q_ny_reg <= e_ny_reg;

        sq_reg[0].zero <= (q_mx_reg == '0) && (q_my_reg == '0);
        sq_reg[0].nx   <= q_nx_reg;
        sq_reg[0].ny   <= q_ny_reg;
        sq_reg[0].mx   <= q_mx_reg;
        sq_reg[0].my   <= q_my_reg;
        sq_reg[0].n    <= {2'b0, q_sx_reg} + {2'b0, q_sy_reg};
        sq_reg[0].rem  <= '0;
        sq_reg[0].root <= '0;
    end

    // one root bit per stage, high pair first
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam int J = SQRT_STEPS - 1 - k;
        logic [35:0] t;
        logic [35:0] trial;
        sq_t         sq_next;

        assign t     = {sq_reg[k].rem, sq_reg[k].n[2*J+1 -: 2]};
        assign trial = {2'b00, sq_reg[k].root, 2'b01};

        always_comb
        begin
            sq_next = sq_reg[k];
            if (t >= trial)
            begin
                sq_next.rem  = 34'(t - trial);
                sq_next.root = {sq_reg[k].root[30:0], 1'b1};
            end
            else
            begin
                sq_next.rem  = t[33:0];
                sq_next.root = {sq_reg[k].root[30:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            sq_reg[k+1] <= sq_next;
        end
    end

    // dividend is m << 30; its top bits m >> 1 are already below the length
    always_comb
    begin
        dv_in.zero = sq_reg[SQRT_STEPS].zero;
        dv_in.nx   = sq_reg[SQRT_STEPS].nx;
        dv_in.ny   = sq_reg[SQRT_STEPS].ny;
        dv_in.bx   = sq_reg[SQRT_STEPS].mx[0];
        dv_in.by   = sq_reg[SQRT_STEPS].my[0];
        dv_in.len  = sq_reg[SQRT_STEPS].root;
        dv_in.remx = {2'b0, sq_reg[SQRT_STEPS].mx[30:1]};
        dv_in.remy = {2'b0, sq_reg[SQRT_STEPS].my[30:1]};
        dv_in.qx   = '0;
        dv_in.qy   = '0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        dv_t         cur;
        dv_t         dv_next;
        logic        inx;
        logic        iny;
        logic [32:0] tx;
        logic [32:0] ty;

        if (k == 0)
        begin : g_first
            assign cur = dv_in;
            assign inx = dv_in.bx;
            assign iny = dv_in.by;
        end
        else
        begin : g_rest
            assign cur = dv_reg[k];
            assign inx = 1'b0;
            assign iny = 1'b0;
        end

        assign tx = {cur.remx, inx};
        assign ty = {cur.remy, iny};

        always_comb
        begin
            dv_next = cur;
            if (tx >= {1'b0, cur.len})
            begin
                dv_next.remx = 32'(tx - {1'b0, cur.len});
                dv_next.qx   = {cur.qx[29:0], 1'b1};
            end
            else
            begin
                dv_next.remx = tx[31:0];
                dv_next.qx   = {cur.qx[29:0], 1'b0};
            end
            if (ty >= {1'b0, cur.len})
            begin
                dv_next.remy = 32'(ty - {1'b0, cur.len});
                dv_next.qy   = {cur.qy[29:0], 1'b1};
            end
            else
            begin
                dv_next.remy = ty[31:0];
                dv_next.qy   = {cur.qy[29:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            dv_reg[k+1] <= dv_next;
        end
    end

    // zero edge gives a zero axis
    always_ff @(posedge clk)
    begin
        if (dv_reg[DIV_STEPS].zero)
        begin
            axis_x_reg <= '0;
            axis_y_reg <= '0;
        end
        else
        begin
            axis_x_reg <= dv_reg[DIV_STEPS].nx ? -$signed({1'b0, dv_reg[DIV_STEPS].qx})
                                               :  $signed({1'b0, dv_reg[DIV_STEPS].qx});
            axis_y_reg <= dv_reg[DIV_STEPS].ny ? -$signed({1'b0, dv_reg[DIV_STEPS].qy})
                                               :  $signed({1'b0, dv_reg[DIV_STEPS].qy});
        end
    end

    assign axis_x = axis_x_reg;
    assign axis_y = axis_y_reg;

endmodule

// ===== hw/rtl/obb_pair_sat_collision_resolve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obb_pair_sat_collision_resolve
// Separating axis test of two oriented rectangles on four axes, with push
// apart along the least overlap axis and speed scaling on a hit.
// ----------------------------------------------------------------------------
// Path from start to done: the axis unit (square root and division one bit per
// stage), then the stages for projections, overlap and push.
// Throughput: one pair per cycle; busy stays low and results cannot be held.
// Reset: rst_n clears all valid bits and sets mult_reg to 32768.
module obb_pair_sat_collision_resolve
    import obbsat_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [16:0]        cfg_data,
    input  logic [63:0]        corner_a0,
    input  logic [63:0]        corner_a1,
    input  logic [63:0]        corner_a2,
    input  logic [63:0]        corner_a3,
    input  logic [63:0]        corner_b0,
    input  logic [63:0]        corner_b1,
    input  logic [63:0]        corner_b2,
    input  logic [63:0]        corner_b3,
    input  logic [63:0]        centre_a,
    input  logic [63:0]        centre_b,
    input  logic signed [31:0] speed_a,
    input  logic signed [31:0] speed_b,
    output logic               hit,
    output logic [63:0]        new_centre_a,
    output logic [63:0]        new_centre_b,
    output logic signed [31:0] new_speed_a,
    output logic signed [31:0] new_speed_b
);

    logic [16:0] mult_reg;

    pass_t                pass_in;
    pass_t                pline_reg [AXIS_LAT];
    logic [AXIS_LAT-1:0]  vline_reg;
    logic [POST_LAT-1:0]  pv_reg;

    logic signed [31:0] ua_x;
    logic signed [31:0] ua_y;
    logic signed [31:0] ub_x;
    logic signed [31:0] ub_y;

    pass_t              ph;
    logic signed [31:0] cx [8];
    logic signed [31:0] cy [8];
    logic signed [31:0] axx [4];
    logic signed [31:0] axy [4];
    logic signed [32:0] dcx;
    logic signed [32:0] dcy;

    // s1 .. s8 side data, s1 .. s6 axes
    side_t              side_reg [POST_LAT-1];
    logic signed [31:0] cax_reg [6][4];
    logic signed [31:0] cay_reg [6][4];

    logic signed [63:0] prx_reg [8][4];
    logic signed [63:0] pry_reg [8][4];
    logic signed [63:0] dpx_reg [4];
    logic signed [63:0] dpy_reg [4];
    logic signed [63:0] proj_reg [8][4];
    logic [3:0]         dn_reg [5];
    logic signed [63:0] mn_reg [2][4][2];
    logic signed [63:0] mx_reg [2][4][2];
    logic signed [63:0] lo_reg [2][4];
    logic signed [63:0] hi_reg [2][4];
    logic [3:0]         sep_reg;
    logic [63:0]        ov_reg [4];
    logic               hit6_reg;
    logic [63:0]        ov01_reg;
    logic [63:0]        ov23_reg;
    logic               i01_reg;
    logic               i23_reg;
    logic               hit7_reg;
    logic signed [31:0] bx_reg;
    logic signed [31:0] by_reg;
    logic [32:0]        half_reg;
    logic               hit8_reg;
    logic [63:0]        pmx_reg;
    logic [63:0]        pmy_reg;
    logic               nx8_reg;
    logic               ny8_reg;
    logic [48:0]        sma_reg;
    logic [48:0]        smb_reg;
    logic               sna_reg;
    logic               snb_reg;

    logic               hit_reg;
    logic [63:0]        nca_reg;
    logic [63:0]        ncb_reg;
    logic signed [31:0] nsa_reg;
    logic signed [31:0] nsb_reg;

    logic [1:0]         sel;
    logic [63:0]        best_ov;
    logic               flip;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic [30:0]        bxm;
    logic [30:0]        bym;
    logic [31:0]        sam;
    logic [31:0]        sbm;
    logic signed [35:0] psx;
    logic signed [35:0] psy;
    logic signed [34:0] ssa;
    logic signed [34:0] ssb;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg  <= MULT_RESET;
            vline_reg <= '0;
            pv_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                mult_reg <= cfg_data;
            vline_reg <= {vline_reg[AXIS_LAT-2:0], start && !busy};
            pv_reg    <= {pv_reg[POST_LAT-2:0], vline_reg[AXIS_LAT-1]};
        end
    end

    always_comb
    begin
        pass_in.corner[0] = corner_a0;
        pass_in.corner[1] = corner_a1;
        pass_in.corner[2] = corner_a2;
        pass_in.corner[3] = corner_a3;
        pass_in.corner[4] = corner_b0;
        pass_in.corner[5] = corner_b1;
        pass_in.corner[6] = corner_b2;
        pass_in.corner[7] = corner_b3;
        pass_in.ctr_a     = centre_a;
        pass_in.ctr_b     = centre_b;
        pass_in.spd_a     = speed_a;
        pass_in.spd_b     = speed_b;
    end

    always_ff @(posedge clk)
    begin
        pline_reg[0] <= pass_in;
        for (int i = 1; i < AXIS_LAT; i++)
            pline_reg[i] <= pline_reg[i-1];
    end

    obbsat_axis u_axis_a (
        .clk    (clk),
        .p0     (corner_a0),
        .p1     (corner_a1),
        .axis_x (ua_x),
        .axis_y (ua_y)
    );

    obbsat_axis u_axis_b (
        .clk    (clk),
        .p0     (corner_b0),
        .p1     (corner_b1),
        .axis_x (ub_x),
        .axis_y (ub_y)
    );

    // axis order: A edge, A perpendicular, B edge, B perpendicular
    always_comb
    begin
        ph = pline_reg[AXIS_LAT-1];
        for (int k = 0; k < 8; k++)
        begin
            cx[k] = $signed(ph.corner[k][63:32]);
            cy[k] = $signed(ph.corner[k][31:0]);
        end
        axx[0] = ua_x;
        axy[0] = ua_y;
        axx[1] = -ua_y;
        axy[1] = ua_x;
        axx[2] = ub_x;
        axy[2] = ub_y;
        axx[3] = -ub_y;
        axy[3] = ub_x;
        dcx = $signed({ph.ctr_a[63], ph.ctr_a[63:32]}) - $signed({ph.ctr_b[63], ph.ctr_b[63:32]});
        dcy = $signed({ph.ctr_a[31], ph.ctr_a[31:0]}) - $signed({ph.ctr_b[31], ph.ctr_b[31:0]});
    end

    // least overlap pick, earlier axis wins ties
    always_comb
    begin
        if (ov23_reg < ov01_reg)
        begin
            sel     = {1'b1, i23_reg};
            best_ov = ov23_reg;
        end
        else
        begin
            sel     = {1'b0, i01_reg};
            best_ov = ov01_reg;
        end
        flip = dn_reg[4][sel];
        bx   = cax_reg[5][sel];
        by   = cay_reg[5][sel];

        bxm = bx_reg[31] ? 31'(-bx_reg) : bx_reg[30:0];
        bym = by_reg[31] ? 31'(-by_reg) : by_reg[30:0];
        sam = side_reg[6].spd_a[31] ? 32'(-side_reg[6].spd_a) : side_reg[6].spd_a;
        sbm = side_reg[6].spd_b[31] ? 32'(-side_reg[6].spd_b) : side_reg[6].spd_b;

        psx = nx8_reg ? -$signed({2'b00, pmx_reg[63:30]}) : $signed({2'b00, pmx_reg[63:30]});
        psy = ny8_reg ? -$signed({2'b00, pmy_reg[63:30]}) : $signed({2'b00, pmy_reg[63:30]});
        ssa = sna_reg ? -$signed({2'b00, sma_reg[48:16]}) : $signed({2'b00, sma_reg[48:16]});
        ssb = snb_reg ? -$signed({2'b00, smb_reg[48:16]}) : $signed({2'b00, smb_reg[48:16]});
    end

    always_ff @(posedge clk)
    begin
        // s1: corner and centre offset products
        side_reg[0].ctr_a <= ph.ctr_a;
        side_reg[0].ctr_b <= ph.ctr_b;
        side_reg[0].spd_a <= ph.spd_a;
        side_reg[0].spd_b <= ph.spd_b;
        for (int i = 1; i < POST_LAT - 1; i++)
            side_reg[i] <= side_reg[i-1];
        for (int a = 0; a < 4; a++)
        begin
            cax_reg[0][a] <= axx[a];
            cay_reg[0][a] <= axy[a];
            for (int i = 1; i < 6; i++)
            begin
                cax_reg[i][a] <= cax_reg[i-1][a];
                cay_reg[i][a] <= cay_reg[i-1][a];
            end
            for (int k = 0; k < 8; k++)
            begin
                prx_reg[k][a] <= cx[k] * axx[a];
                pry_reg[k][a] <= cy[k] * axy[a];
            end
            dpx_reg[a] <= dcx * axx[a];
            dpy_reg[a] <= dcy * axy[a];
        end

        // s2: projections, centre direction sign
        for (int a = 0; a < 4; a++)
        begin
            for (int k = 0; k < 8; k++)
                proj_reg[k][a] <= prx_reg[k][a] + pry_reg[k][a];
            dn_reg[0][a] <= 1'(65'(dpx_reg[a]) + 65'(dpy_reg[a]) >>> 64);
        end
        for (int i = 1; i < 5; i++)
            dn_reg[i] <= dn_reg[i-1];

        // s3, s4: extents of each rectangle
        for (int r = 0; r < 2; r++)
        begin
            for (int a = 0; a < 4; a++)
            begin
                for (int h = 0; h < 2; h++)
                begin
                    if (proj_reg[4*r+2*h+1][a] < proj_reg[4*r+2*h][a])
                    begin
                        mn_reg[r][a][h] <= proj_reg[4*r+2*h+1][a];
                        mx_reg[r][a][h] <= proj_reg[4*r+2*h][a];
                    end
                    else
                    begin
                        mn_reg[r][a][h] <= proj_reg[4*r+2*h][a];
                        mx_reg[r][a][h] <= proj_reg[4*r+2*h+1][a];
                    end
                end
                lo_reg[r][a] <= (mn_reg[r][a][1] < mn_reg[r][a][0]) ? mn_reg[r][a][1]
                                                                    : mn_reg[r][a][0];
                hi_reg[r][a] <= (mx_reg[r][a][1] > mx_reg[r][a][0]) ? mx_reg[r][a][1]
                                                                    : mx_reg[r][a][0];
            end
        end

        // s5: separation and overlap per axis
        for (int a = 0; a < 4; a++)
        begin
            sep_reg[a] <= (hi_reg[0][a] < lo_reg[1][a]) || (hi_reg[1][a] < lo_reg[0][a]);
            ov_reg[a]  <= 64'(((hi_reg[0][a] < hi_reg[1][a]) ? hi_reg[0][a] : hi_reg[1][a])
                            - ((lo_reg[0][a] > lo_reg[1][a]) ? lo_reg[0][a] : lo_reg[1][a]));
        end

        // s6: hit flag, pairwise minimum
        hit6_reg <= (sep_reg == '0);
        i01_reg  <= (ov_reg[1] < ov_reg[0]);
        ov01_reg <= (ov_reg[1] < ov_reg[0]) ? ov_reg[1] : ov_reg[0];
        i23_reg  <= (ov_reg[3] < ov_reg[2]);
        ov23_reg <= (ov_reg[3] < ov_reg[2]) ? ov_reg[3] : ov_reg[2];

        // s7: chosen axis turned toward A, half overlap
        hit7_reg <= hit6_reg;
        bx_reg   <= flip ? -bx : bx;
        by_reg   <= flip ? -by : by;
        half_reg <= best_ov[63:31];

        // s8: push and speed products
        hit8_reg <= hit7_reg;
        pmx_reg  <= {33'b0, bxm} * {31'b0, half_reg};
        pmy_reg  <= {33'b0, bym} * {31'b0, half_reg};
        nx8_reg  <= bx_reg[31];
        ny8_reg  <= by_reg[31];
        sma_reg  <= {17'b0, sam} * {32'b0, mult_reg};
        smb_reg  <= {17'b0, sbm} * {32'b0, mult_reg};
        sna_reg  <= side_reg[6].spd_a[31];
        snb_reg  <= side_reg[6].spd_b[31];

        // s9: saturate and select
        hit_reg <= hit8_reg;
        if (hit8_reg)
        begin
            nca_reg[63:32] <= sat32(36'($signed(side_reg[7].ctr_a[63:32])) + psx);
            nca_reg[31:0]  <= sat32(36'($signed(side_reg[7].ctr_a[31:0])) + psy);
            ncb_reg[63:32] <= sat32(36'($signed(side_reg[7].ctr_b[63:32])) - psx);
            ncb_reg[31:0]  <= sat32(36'($signed(side_reg[7].ctr_b[31:0])) - psy);
            nsa_reg        <= sat32(36'(ssa));
            nsb_reg        <= sat32(36'(ssb));
        end
        else
        begin
            nca_reg <= side_reg[7].ctr_a;
            ncb_reg <= side_reg[7].ctr_b;
            nsa_reg <= side_reg[7].spd_a;
            nsb_reg <= side_reg[7].spd_b;
        end
    end

    assign done         = pv_reg[POST_LAT-1];
    assign hit          = hit_reg;
    assign new_centre_a = nca_reg;
    assign new_centre_b = ncb_reg;
    assign new_speed_a  = nsa_reg;
    assign new_speed_b  = nsb_reg;

`ifndef SYNTHESIS
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TOTAL_LAT))
        else $error("done without a matching start");

    a_miss_centres: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> new_centre_a == $past(centre_a, TOTAL_LAT) &&
                         new_centre_b == $past(centre_b, TOTAL_LAT))
        else $error("centres changed on a miss");

    a_miss_speeds: assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> new_speed_a == $past(speed_a, TOTAL_LAT) &&
                         new_speed_b == $past(speed_b, TOTAL_LAT))
        else $error("speeds changed on a miss");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rectangle pair collision block: a queue-fed
// driver, a strobe monitor and an in-bench predictor of the separating axis
// test, push-apart and speed scaling, run over several multiplier settings.
// ----------------------------------------------------------------------------
module tb_top
    import obbsat_pkg::*;
();

    localparam int LIMIT_CYCLES = 400000;

    typedef struct {
        bit [63:0] corner [8];
        bit [63:0] ctr_a;
        bit [63:0] ctr_b;
        bit [31:0] spd_a;
        bit [31:0] spd_b;
    } pair_t;

    typedef struct {
        bit        hit;
        bit [63:0] ctr_a;
        bit [63:0] ctr_b;
        bit [31:0] spd_a;
        bit [31:0] spd_b;
    } resolve_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               done;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [16:0]        cfg_data = '0;
    logic [63:0]        corner_a0 = '0, corner_a1 = '0, corner_a2 = '0, corner_a3 = '0;
    logic [63:0]        corner_b0 = '0, corner_b1 = '0, corner_b2 = '0, corner_b3 = '0;
    logic [63:0]        centre_a = '0, centre_b = '0;
    logic signed [31:0] speed_a = '0, speed_b = '0;
    logic               hit;
    logic [63:0]        new_centre_a, new_centre_b;
    logic signed [31:0] new_speed_a, new_speed_b;

    pair_t      pair_q [$];
    resolve_t   resolve_q [$];
    bit [16:0]  mult_q [$];
    pair_t      cur;
    bit [16:0]  mult_now = MULT_RESET;
    int         gap = 0;
    bit         no_idle = 0;
    int         errors = 0;
    int         n_hit = 0;
    int         n_miss = 0;
    int         cycles = 0;

    obb_pair_sat_collision_resolve dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .corner_a0(corner_a0), .corner_a1(corner_a1),
        .corner_a2(corner_a2), .corner_a3(corner_a3),
        .corner_b0(corner_b0), .corner_b1(corner_b1),
        .corner_b2(corner_b2), .corner_b3(corner_b3),
        .centre_a(centre_a), .centre_b(centre_b),
        .speed_a(speed_a), .speed_b(speed_b),
        .hit(hit), .new_centre_a(new_centre_a), .new_centre_b(new_centre_b),
        .new_speed_a(new_speed_a), .new_speed_b(new_speed_b)
    );

    always #2 clk = ~clk;

    // ---------------- predictor ----------------
    function automatic longint sx32(bit [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip_edge(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483647)
            return -64'sd2147483647;
        return v;
    endfunction

    function automatic bit [63:0] magn(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint signed_of(bit [63:0] m, bit neg);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic bit [63:0] int_sqrt(bit [63:0] n);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void unit_axis(bit [63:0] p0, bit [63:0] p1,
                                      output longint ux, output longint uy);
        longint ex, ey;
        bit [63:0] mx, my, len;
        ex = clip_edge(sx32(p1[63:32]) - sx32(p0[63:32]));
        ey = clip_edge(sx32(p1[31:0]) - sx32(p0[31:0]));
        mx = magn(ex);
        my = magn(ey);
        ux = 0;
        uy = 0;
        if (mx != 0 || my != 0)
        begin
            len = int_sqrt(mx * mx + my * my);
            ux = signed_of((mx << AXIS_BITS) / len, ex < 0);
            uy = signed_of((my << AXIS_BITS) / len, ey < 0);
        end
    endfunction

    function automatic longint scale_speed(bit [31:0] s, bit [16:0] m);
        longint v;
        bit [63:0] p;
        v = sx32(s);
        p = (magn(v) * 64'(m)) >> MULT_BITS;
        return clip32(signed_of(p, v < 0));
    endfunction

    function automatic bit [63:0] pack_pt(longint x, longint y);
        return {x[31:0], y[31:0]};
    endfunction

    function automatic resolve_t resolve_pair(pair_t p, bit [16:0] m);
        resolve_t r;
        longint ax [4], ay [4];
        longint lo_a, hi_a, lo_b, hi_b, lo, hi, pr, bx, by, d1, d2, px, py;
        bit [63:0] ov, best_ov, half;
        bit ok;
        ok = 1;
        best_ov = 0;
        unit_axis(p.corner[0], p.corner[1], ax[0], ay[0]);
        ax[1] = -ay[0];
        ay[1] = ax[0];
        unit_axis(p.corner[4], p.corner[5], ax[2], ay[2]);
        ax[3] = -ay[2];
        ay[3] = ax[2];
        bx = ax[0];
        by = ay[0];
        for (int i = 0; i < 4 && ok; i++)
        begin
            for (int k = 0; k < 8; k++)
            begin
                pr = sx32(p.corner[k][63:32]) * ax[i] + sx32(p.corner[k][31:0]) * ay[i];
                if (k == 0)
                begin
                    lo_a = pr;
                    hi_a = pr;
                end
                else if (k == 4)
                begin
                    lo_b = pr;
                    hi_b = pr;
                end
                else if (k < 4)
                begin
                    if (pr < lo_a) lo_a = pr;
                    if (pr > hi_a) hi_a = pr;
                end
                else
                begin
                    if (pr < lo_b) lo_b = pr;
                    if (pr > hi_b) hi_b = pr;
                end
            end
            if (hi_a < lo_b || hi_b < lo_a)
                ok = 0;
            else
            begin
                hi = (hi_a < hi_b) ? hi_a : hi_b;
                lo = (lo_a > lo_b) ? lo_a : lo_b;
                ov = 64'(hi) - 64'(lo);
                if (i == 0 || ov < best_ov)
                begin
                    best_ov = ov;
                    bx = ax[i];
                    by = ay[i];
                end
            end
        end
        r.hit = ok;
        if (!ok)
        begin
            r.ctr_a = p.ctr_a;
            r.ctr_b = p.ctr_b;
            r.spd_a = p.spd_a;
            r.spd_b = p.spd_b;
            return r;
        end
        d1 = (sx32(p.ctr_a[63:32]) - sx32(p.ctr_b[63:32])) * bx;
        d2 = (sx32(p.ctr_a[31:0]) - sx32(p.ctr_b[31:0])) * by;
        // flip so the axis points from B toward A
        if (d1 < -d2)
        begin
            bx = -bx;
            by = -by;
        end
        half = best_ov >> (AXIS_BITS + 1);
        px = signed_of((magn(bx) * half) >> AXIS_BITS, bx < 0);
        py = signed_of((magn(by) * half) >> AXIS_BITS, by < 0);
        r.ctr_a = pack_pt(clip32(sx32(p.ctr_a[63:32]) + px), clip32(sx32(p.ctr_a[31:0]) + py));
        r.ctr_b = pack_pt(clip32(sx32(p.ctr_b[63:32]) - px), clip32(sx32(p.ctr_b[31:0]) - py));
        r.spd_a = 32'(scale_speed(p.spd_a, m));
        r.spd_b = 32'(scale_speed(p.spd_b, m));
        return r;
    endfunction

    // ---------------- stimulus builders ----------------
    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // well-formed rectangle pair, mostly near each other
    function automatic pair_t make_pair(int sh, bit far_off);
        pair_t p;
        longint sc, bxa, bya, ex, ey, fx, fy, k, ox, oy;
        sc = longint'(1) << sh;
        for (int r = 0; r < 2; r++)
        begin
            ex = (longint'($urandom_range(0, 128)) - 64) * sc;
            ey = (longint'($urandom_range(0, 128)) - 64) * sc;
            k = $urandom_range(1, 8);
            fx = -ey * k / 4;
            fy = ex * k / 4;
            if (r == 0)
            begin
                bxa = (longint'($urandom_range(0, 512)) - 256) * sc;
                bya = (longint'($urandom_range(0, 512)) - 256) * sc;
            end
            else
            begin
                ox = (longint'($urandom_range(0, 200)) - 100) * sc;
                oy = (longint'($urandom_range(0, 200)) - 100) * sc;
                if (far_off)
                begin
                    ox = ox * 8;
                    oy = oy * 8;
                end
                bxa = bxa + ox;
                bya = bya + oy;
            end
            p.corner[4*r]     = pack_pt(bxa, bya);
            p.corner[4*r + 1] = pack_pt(bxa + ex, bya + ey);
            p.corner[4*r + 2] = pack_pt(bxa + ex + fx, bya + ey + fy);
            p.corner[4*r + 3] = pack_pt(bxa + fx, bya + fy);
            if (r == 0)
                p.ctr_a = pack_pt(bxa + (ex + fx) / 2, bya + (ey + fy) / 2);
            else
                p.ctr_b = pack_pt(bxa + (ex + fx) / 2, bya + (ey + fy) / 2);
        end
        if ($urandom_range(0, 15) == 0)
            p.ctr_b = p.ctr_a;
        p.spd_a = $urandom;
        p.spd_b = $urandom;
        return p;
    endfunction

    function automatic pair_t noise_pair();
        pair_t p;
        for (int i = 0; i < 8; i++)
            p.corner[i] = rand64();
        p.ctr_a = rand64();
        p.ctr_b = rand64();
        p.spd_a = $urandom;
        p.spd_b = $urandom;
        return p;
    endfunction

    function automatic pair_t box_pair(longint ax0, longint ay0, longint aw, longint ah,
                                       longint bx0, longint by0, longint bw, longint bh);
        pair_t p;
        p.corner[0] = pack_pt(ax0, ay0);
        p.corner[1] = pack_pt(ax0 + aw, ay0);
        p.corner[2] = pack_pt(ax0 + aw, ay0 + ah);
        p.corner[3] = pack_pt(ax0, ay0 + ah);
        p.corner[4] = pack_pt(bx0, by0);
        p.corner[5] = pack_pt(bx0 + bw, by0);
        p.corner[6] = pack_pt(bx0 + bw, by0 + bh);
        p.corner[7] = pack_pt(bx0, by0 + bh);
        p.ctr_a = pack_pt(ax0 + aw / 2, ay0 + ah / 2);
        p.ctr_b = pack_pt(bx0 + bw / 2, by0 + bh / 2);
        p.spd_a = 32'h7FFF_FFFF;
        p.spd_b = 32'h8000_0000;
        return p;
    endfunction

    // ---------------- driver ----------------
    always @(posedge clk)
    begin
        bit nstart;
        nstart = start;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                resolve_q.insert(resolve_q.size(), resolve_pair(cur, mult_now));
                gap = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (!start || !busy)
            begin
                if (gap > 0)
                begin
                    gap--;
                    nstart = 0;
                end
                else if (pair_q.size() > 0)
                begin
                    cur = pair_q.pop_front();
                    corner_a0 <= cur.corner[0];
                    corner_a1 <= cur.corner[1];
                    corner_a2 <= cur.corner[2];
                    corner_a3 <= cur.corner[3];
                    corner_b0 <= cur.corner[4];
                    corner_b1 <= cur.corner[5];
                    corner_b2 <= cur.corner[6];
                    corner_b3 <= cur.corner[7];
                    centre_a  <= cur.ctr_a;
                    centre_b  <= cur.ctr_b;
                    speed_a   <= cur.spd_a;
                    speed_b   <= cur.spd_b;
                    nstart = 1;
                end
                else
                    nstart = 0;
            end
        end
        start <= nstart;
    end

    // config word driver
    always @(posedge clk)
    begin
        bit nvalid;
        nvalid = cfg_valid;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                mult_now = cfg_data;
                nvalid = 0;
            end
            if (!nvalid && mult_q.size() > 0)
            begin
                cfg_data <= mult_q.pop_front();
                nvalid = 1;
            end
        end
        cfg_valid <= nvalid;
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        resolve_t e;
        if (rst_n && done)
        begin
            if (resolve_q.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                e = resolve_q.pop_front();
                if (e.hit) n_hit++; else n_miss++;
                if (hit !== e.hit)
                begin
                    $error("hit: expected %0d actual %0d", e.hit, hit);
                    errors++;
                end
                if (new_centre_a !== e.ctr_a)
                begin
                    $error("new_centre_a: expected %h actual %h", e.ctr_a, new_centre_a);
                    errors++;
                end
                if (new_centre_b !== e.ctr_b)
                begin
                    $error("new_centre_b: expected %h actual %h", e.ctr_b, new_centre_b);
                    errors++;
                end
                if (new_speed_a !== e.spd_a)
                begin
                    $error("new_speed_a: expected %h actual %h", e.spd_a, new_speed_a);
                    errors++;
                end
                if (new_speed_b !== e.spd_b)
                begin
                    $error("new_speed_b: expected %h actual %h", e.spd_b, new_speed_b);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    task automatic drain();
        do
            @(negedge clk);
        while (pair_q.size() > 0 || start || resolve_q.size() > 0 ||
               mult_q.size() > 0 || cfg_valid);
        repeat (TOTAL_LAT + 4) @(negedge clk);
    endtask

    task automatic add_pair(pair_t p);
        pair_q.insert(pair_q.size(), p);
    endtask

    task automatic add_mult(bit [16:0] m);
        mult_q.insert(mult_q.size(), m);
    endtask

    task automatic random_phase(int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                add_pair(make_pair($urandom_range(4, 20), 0));
            else if (pick < 8)
                add_pair(make_pair($urandom_range(4, 20), 1));
            else
                add_pair(noise_pair());
        end
    endtask

    initial
    begin
        pair_t p;
        longint u;
        u = 64'sd65536;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset multiplier
        add_pair(box_pair(0, 0, u, u, u, 0, u, u));                   // touching
        add_pair(box_pair(0, 0, u, u, u + 1, 0, u, u));               // just apart
        add_pair(box_pair(0, 0, 2*u, 2*u, u, u/2, 2*u, u));           // overlap
        add_pair(box_pair(0, 0, u, u, 0, 0, u, u));                   // same centres
        add_pair(box_pair(5*u, 5*u, 0, u, 5*u, 5*u, u, u));           // zero edge A
        add_pair(box_pair(0, 0, 0, 0, 0, 0, 0, 0));                   // all zero
        p = box_pair(64'sh7FFF0000, 64'sh7FFF0000, u, u, 64'sh7FFF8000, 64'sh7FFF0000, u, u);
        add_pair(p);                                                  // saturating push
        p = box_pair(-64'sh80000000, -64'sh80000000, u, u,
                     -64'sh80000000 + u/2, -64'sh80000000, u, u);
        add_pair(p);
        for (int i = 0; i < 8; i++)
            p.corner[i] = '1;
        p.ctr_a = '1;
        p.ctr_b = '0;
        p.spd_a = '1;
        p.spd_b = '0;
        add_pair(p);
        p.corner[1] = 64'h7FFFFFFF_7FFFFFFF;
        p.corner[0] = 64'h80000000_80000000;
        p.corner[5] = 64'h80000000_7FFFFFFF;
        p.corner[4] = 64'h7FFFFFFF_80000000;
        add_pair(p);                                                  // clipped edges
        for (int i = 0; i < 8; i++)
            add_pair(make_pair(16, 0));
        random_phase(150);
        drain();

        add_mult(17'd0);
        drain();
        no_idle = 1;
        random_phase(120);
        drain();
        no_idle = 0;

        add_mult(17'd65536);
        drain();
        random_phase(150);
        drain();

        add_mult(17'h1FFFF);                                          // scales up
        drain();
        add_pair(box_pair(0, 0, u, u, 0, 0, u, u));
        random_phase(150);
        drain();

        add_mult(17'($urandom));
        drain();
        random_phase(150);
        drain();

        $display("covered %0d hit and %0d miss pairs over five multiplier settings",
                 n_hit, n_miss);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
